// File: hdl/albers_forward_projection_core_defines.svh
// ----------------------------------------------------------------------------
// albers forward projection core: assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ALBERS_FORWARD_PROJECTION_CORE_DEFINES_SVH
`define ALBERS_FORWARD_PROJECTION_CORE_DEFINES_SVH

// expression that must hold at every edge
`define AFP_ASSERT_NOW(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// antecedent implies consequent sequence
`define AFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`endif

// File: hdl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg
// types, constants and shared arithmetic for the albers projection pipeline
// ----------------------------------------------------------------------------
package afp_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 24;
	localparam int DIST_FRAC_BITS_DEF  = 8;

	// q30 fixed point values carried through the trig and series stages
	localparam int Q30_W = 34;
	typedef logic signed [Q30_W-1:0] q30_t;

	localparam q30_t ONE_Q30 = 34'sd1073741824;
	localparam q30_t ECC_Q30 = 34'sd88338731;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;

	localparam int SIN_N = 4;
	localparam int COS_N = 5;
	localparam int SER_N = 7;
	localparam q30_t SIN_SEED = 34'sd2959;
	localparam q30_t COS_SEED = 34'sd296;
	localparam q30_t SER_SEED = 34'sd572662306;
	localparam q30_t SIN_COEF [SIN_N] = '{34'sd213044, 34'sd8947849, 34'sd178956971,
		34'sd1073741824};
	localparam q30_t COS_COEF [COS_N] = '{34'sd26631, 34'sd1491308, 34'sd44739243,
		34'sd536870912, 34'sd1073741824};
	localparam q30_t SER_COEF [SER_N] = '{34'sd578168674, 34'sd585677359, 34'sd596523236,
		34'sd613566757, 34'sd644245094, 34'sd715827883, 34'sd1073741824};

	// square root chain
	localparam int ROOT_W = 43;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;

	// cycles from accepted request to result strobe
	localparam int PIPE_LAT = 73;

	typedef enum logic [2:0] {
		REG_CENTRAL_LON   = 3'd0,
		REG_CONE_CONST    = 3'd1,
		REG_RHO_ORIGIN_SQ = 3'd2,
		REG_RADIUS_TERM   = 3'd3,
		REG_RHO_BASE      = 3'd4,
		REG_FALSE_EASTING = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	localparam logic signed [32:0] CENTRAL_LON_RST = 33'sd1610612736;
	localparam logic [40:0] CONE_CONST_RST   = 41'd11569777303;
	localparam logic [50:0] RHO_ORIGIN_SQ_RST = 51'd150995771793488;
	localparam logic [50:0] RADIUS_TERM_RST  = 51'd134038556964216;
	localparam logic [33:0] RHO_BASE_RST     = 34'd2541844367;
	localparam logic signed [34:0] FALSE_EASTING_RST = 35'sd0;

	// signed q30 product, magnitude rounded half up
	function automatic q30_t q30_mul(input q30_t a, input q30_t b);
		logic [Q30_W-1:0] ma;
		logic [Q30_W-1:0] mb;
		logic [2*Q30_W-1:0] p;
		q30_t m;
		ma = a[Q30_W-1] ? Q30_W'(-a) : Q30_W'(a);
		mb = b[Q30_W-1] ? Q30_W'(-b) : Q30_W'(b);
		p = (2*Q30_W)'(ma) * (2*Q30_W)'(mb) + (2*Q30_W)'(536870912);
		m = q30_t'(p[Q30_W+29:30]);
		return (a[Q30_W-1] ^ b[Q30_W-1]) ? -m : m;
	endfunction

endpackage

// File: hdl/afp_dly.sv
// ----------------------------------------------------------------------------
// afp_dly
// fixed-depth register line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module afp_dly import afp_pkg::*; #(
	parameter int W = Q30_W,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		tap_q[0] <= din;
		for (int i = 1; i < D; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[D-1];

endmodule

// File: hdl/afp_mul.sv
// ----------------------------------------------------------------------------
// afp_mul
// two-stage unsigned multiplier: four half-width partial products, then sum
// ----------------------------------------------------------------------------
module afp_mul import afp_pkg::*; #(
	parameter int AW = Q30_W,
	parameter int BW = Q30_W
) (
	input  logic             clk,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] prod
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [PW-1:0]    prod_s2;

	always_ff @(posedge clk) begin
		ll_s1 <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
		lh_s1 <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
		hl_s1 <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
		hh_s1 <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
		prod_s2 <= PW'(ll_s1) + (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL)
			+ (PW'(hh_s1) << (AL + BL));
	end

	assign prod = prod_s2;

endmodule

// File: hdl/afp_horner_cell.sv
// ----------------------------------------------------------------------------
// afp_horner_cell
// one horner step t' = coef +/- x*t in q30, x handed on to the next cell
// ----------------------------------------------------------------------------
module afp_horner_cell import afp_pkg::*; #(
	parameter q30_t COEF = ONE_Q30,
	parameter bit   SUB  = 1'b1
) (
	input  logic clk,
	input  q30_t x_in,
	input  q30_t t_in,
	output q30_t x_out,
	output q30_t t_out
);

	q30_t x_s1;
	q30_t t_s1;
	q30_t prod;

	always_comb begin
		prod = q30_mul(x_in, t_in);
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_in;
		t_s1 <= SUB ? COEF - prod : COEF + prod;
	end

	assign x_out = x_s1;
	assign t_out = t_s1;

endmodule

// File: hdl/afp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// afp_sqrt_cell
// one digit of a restoring square root: two radicand bits in, one root bit out
// ----------------------------------------------------------------------------
module afp_sqrt_cell import afp_pkg::*; (
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad_in,
	input  logic [REM_W-1:0]  rem_in,
	input  logic [ROOT_W-1:0] root_in,
	output logic [RAD_W-1:0]  rad_out,
	output logic [REM_W-1:0]  rem_out,
	output logic [ROOT_W-1:0] root_out
);

	logic [RAD_W-1:0]  rad_s1;
	logic [REM_W-1:0]  rem_s1;
	logic [ROOT_W-1:0] root_s1;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;

	always_comb begin
		rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		trial  = REM_W'({root_in, 2'b01});
	end

	always_ff @(posedge clk) begin
		rad_s1 <= rad_in << 2;
		if (rem_sh >= trial) begin
			rem_s1  <= rem_sh - trial;
			root_s1 <= {root_in[ROOT_W-2:0], 1'b1};
		end else begin
			rem_s1  <= rem_sh;
			root_s1 <= {root_in[ROOT_W-2:0], 1'b0};
		end
	end

	assign rad_out  = rad_s1;
	assign rem_out  = rem_s1;
	assign root_out = root_s1;

endmodule

// File: hdl/afp_sincos.sv
// ----------------------------------------------------------------------------
// afp_sincos
// q30 sine and cosine of an angle in quarter turns
// ----------------------------------------------------------------------------
module afp_sincos import afp_pkg::*; (
	input  logic        clk,
	input  logic [33:0] quarter,
	input  logic        neg,
	output q30_t        sin_val,
	output q30_t        cos_val
);

	logic [1:0]  k_s1;
	q30_t        r_s1;
	logic        neg_s1;
	q30_t        r_s2;
	q30_t        s2_s2;
	logic [1:0]  k_s2;
	logic        neg_s2;
	q30_t        sv_s7;
	q30_t        sin_s8;
	q30_t        cos_s8;
	logic [31:0] mfr;
	logic [62:0] pr;
	q30_t        rmag;
	q30_t        r_d;
	logic [2:0]  kn_d;
	q30_t        sn;
	q30_t        cs;

	q30_t sx_w [SIN_N+1];
	q30_t st_w [SIN_N+1];
	q30_t cx_w [COS_N+1];
	q30_t ct_w [COS_N+1];

	// residual in [-1/2, 1/2) quarter turn, scaled by pi/2
	always_comb begin
		mfr  = quarter[31] ? 32'(-$signed(quarter[31:0])) : quarter[31:0];
		pr   = 63'(mfr) * 63'(HALF_PI_Q30) + 63'(32'h80000000);
		rmag = q30_t'(pr[62:32]);
	end

	always_ff @(posedge clk) begin
		k_s1   <= quarter[33:32] + 2'(quarter[31]);
		r_s1   <= quarter[31] ? -rmag : rmag;
		neg_s1 <= neg;
		r_s2   <= r_s1;
		s2_s2  <= q30_mul(r_s1, r_s1);
		k_s2   <= k_s1;
		neg_s2 <= neg_s1;
	end

	assign sx_w[0] = s2_s2;
	assign st_w[0] = SIN_SEED;
	assign cx_w[0] = s2_s2;
	assign ct_w[0] = COS_SEED;

	for (genvar i = 0; i < SIN_N; i++) begin : g_sin
		afp_horner_cell #(.COEF(SIN_COEF[i]), .SUB(1'b1)) u_cell (
			.clk  (clk),
			.x_in (sx_w[i]),
			.t_in (st_w[i]),
			.x_out(sx_w[i+1]),
			.t_out(st_w[i+1])
		);
	end

	for (genvar i = 0; i < COS_N; i++) begin : g_cos
		afp_horner_cell #(.COEF(COS_COEF[i]), .SUB(1'b1)) u_cell (
			.clk  (clk),
			.x_in (cx_w[i]),
			.t_in (ct_w[i]),
			.x_out(cx_w[i+1]),
			.t_out(ct_w[i+1])
		);
	end

	afp_dly #(.W(Q30_W), .D(SIN_N)) u_r_dly (
		.clk (clk),
		.din (r_s2),
		.dout(r_d)
	);

	afp_dly #(.W(3), .D(COS_N)) u_kn_dly (
		.clk (clk),
		.din ({k_s2, neg_s2}),
		.dout(kn_d)
	);

	always_ff @(posedge clk) begin
		sv_s7 <= q30_mul(r_d, st_w[SIN_N]);
	end

	// quadrant folding
	always_comb begin
		case (quad_t'(kn_d[2:1]))
			QUAD_0: begin
				sn = sv_s7;
				cs = ct_w[COS_N];
			end
			QUAD_1: begin
				sn = ct_w[COS_N];
				cs = -sv_s7;
			end
			QUAD_2: begin
				sn = -sv_s7;
				cs = -ct_w[COS_N];
			end
			QUAD_3: begin
				sn = -ct_w[COS_N];
				cs = sv_s7;
			end
			default: begin
				sn = sv_s7;
				cs = ct_w[COS_N];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sin_s8 <= kn_d[0] ? -sn : sn;
		cos_s8 <= cs;
	end

	assign sin_val = sin_s8;
	assign cos_val = cos_s8;

endmodule

// File: hdl/albers_forward_projection_core.sv
// ----------------------------------------------------------------------------
// albers forward projection core
// throughput: one point per cycle, busy never rises; the depth is set by the
// 43-cell square root chain and the latitude sine/cosine and series horner chains
// reset: clears the done pipeline and loads the standard register values
// ----------------------------------------------------------------------------
module albers_forward_projection_core import afp_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int DIST_FRAC_BITS  = DIST_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [50:0]        wr_data,
	input  logic signed [31:0] latitude,
	input  logic signed [32:0] longitude,
	output logic               done,
	output logic signed [34:0] northing,
	output logic signed [34:0] easting,
	output logic               out_of_range
);

	localparam int LSH     = 32 - ANGLE_FRAC_BITS;
	localparam int NUM_W   = 64 - ANGLE_FRAC_BITS;
	localparam int DIV_K   = NUM_W + 7;
	localparam int M90_W   = NUM_W + 2;
	localparam logic [63:0] DIV90_M = ((64'd1 << DIV_K) / 64'd90) + 64'd1;
	localparam int ANG_SH  = ANGLE_FRAC_BITS + 8;
	localparam int RADQ_W  = 76 - ANG_SH;
	localparam int RSH     = 16 - DIST_FRAC_BITS;
	localparam int RND     = (RSH == 0) ? 0 : RSH - 1;
	localparam int RHO_W   = ROOT_W + 1;
	localparam int SC_W    = RHO_W + Q30_W;
	localparam int SV_W    = SC_W - 28;
	localparam int SUM_W   = SV_W + 2;
	localparam logic signed [SUM_W-1:0] OUT_LIM = SUM_W'(64'sd8589934592);

	logic               accept;
	logic [PIPE_LAT-1:0] vld_q;

	logic signed [32:0] central_lon_q;
	logic [40:0]        cone_const_q;
	logic [50:0]        rho_origin_sq_q;
	logic [50:0]        radius_term_q;
	logic [33:0]        rho_base_q;
	logic signed [34:0] false_easting_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			central_lon_q   <= CENTRAL_LON_RST;
			cone_const_q    <= CONE_CONST_RST;
			rho_origin_sq_q <= RHO_ORIGIN_SQ_RST;
			radius_term_q   <= RADIUS_TERM_RST;
			rho_base_q      <= RHO_BASE_RST;
			false_easting_q <= FALSE_EASTING_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_CENTRAL_LON:   central_lon_q   <= wr_data[32:0];
				REG_CONE_CONST:    cone_const_q    <= wr_data[40:0];
				REG_RHO_ORIGIN_SQ: rho_origin_sq_q <= wr_data;
				REG_RADIUS_TERM:   radius_term_q   <= wr_data;
				REG_RHO_BASE:      rho_base_q      <= wr_data[33:0];
				REG_FALSE_EASTING: false_easting_q <= wr_data[34:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	// stage 1: magnitudes of the longitude offset and the latitude
	logic signed [33:0] diff;
	logic [33:0]        magdiff_s1;
	logic               dneg_s1;
	logic [31:0]        maglat_s1;
	logic               latneg_s1;

	always_comb begin
		diff = 34'(central_lon_q) - 34'(longitude);
	end

	always_ff @(posedge clk) begin
		magdiff_s1 <= diff[33] ? 34'(-diff) : 34'(diff);
		dneg_s1    <= diff[33];
		maglat_s1  <= latitude[31] ? 32'(-latitude) : 32'(latitude);
		latneg_s1  <= latitude[31];
	end

	// cone angle in quarter turns
	logic [74:0]        prod_a;
	logic [75:0]        radq_sum;
	logic [RADQ_W-1:0]  radq_s4;
	logic [RADQ_W+63:0] prod_b;
	logic               dneg_d;
	q30_t               asin_s14;
	q30_t               acos_s14;

	afp_mul #(.AW(34), .BW(41)) u_mul_angle (
		.clk (clk),
		.a   (magdiff_s1),
		.b   (cone_const_q),
		.prod(prod_a)
	);

	always_comb begin
		radq_sum = 76'(prod_a) + (76'd1 << (ANG_SH - 1));
	end

	always_ff @(posedge clk) begin
		radq_s4 <= RADQ_W'(radq_sum >> ANG_SH);
	end

	afp_mul #(.AW(RADQ_W), .BW(64)) u_mul_turn (
		.clk (clk),
		.a   (radq_s4),
		.b   (TWO_OVER_PI_Q64),
		.prod(prod_b)
	);

	afp_dly #(.W(1), .D(5)) u_dneg_dly (
		.clk (clk),
		.din (dneg_s1),
		.dout(dneg_d)
	);

	afp_sincos u_sincos_angle (
		.clk    (clk),
		.quarter(prod_b[97:64]),
		.neg    (dneg_d),
		.sin_val(asin_s14),
		.cos_val(acos_s14)
	);

	// latitude in quarter turns, divide by 90 through a reciprocal
	logic [NUM_W-1:0]       num_s2;
	logic [NUM_W+M90_W-1:0] prod_c;
	logic                   latneg_d;
	q30_t                   slat_s12;

	always_ff @(posedge clk) begin
		num_s2 <= (NUM_W'(maglat_s1) << LSH) + NUM_W'(45);
	end

	afp_mul #(.AW(NUM_W), .BW(M90_W)) u_mul_div90 (
		.clk (clk),
		.a   (num_s2),
		.b   (M90_W'(DIV90_M)),
		.prod(prod_c)
	);

	afp_dly #(.W(1), .D(3)) u_latneg_dly (
		.clk (clk),
		.din (latneg_s1),
		.dout(latneg_d)
	);

	afp_sincos u_sincos_lat (
		.clk    (clk),
		.quarter(34'(prod_c >> DIV_K)),
		.neg    (latneg_d),
		.sin_val(slat_s12),
		.cos_val()
	);

	// authalic series in x^2 with x = e sin(lat)
	q30_t x_s13;
	q30_t xx_s14;
	q30_t slat_d;
	q30_t ps_s22;
	q30_t ser_x [SER_N+1];
	q30_t ser_t [SER_N+1];

	always_ff @(posedge clk) begin
		x_s13  <= q30_mul(slat_s12, ECC_Q30);
		xx_s14 <= q30_mul(x_s13, x_s13);
	end

	assign ser_x[0] = xx_s14;
	assign ser_t[0] = SER_SEED;

	for (genvar i = 0; i < SER_N; i++) begin : g_ser
		afp_horner_cell #(.COEF(SER_COEF[i]), .SUB(1'b0)) u_cell (
			.clk  (clk),
			.x_in (ser_x[i]),
			.t_in (ser_t[i]),
			.x_out(ser_x[i+1]),
			.t_out(ser_t[i+1])
		);
	end

	afp_dly #(.W(Q30_W), .D(9)) u_slat_dly (
		.clk (clk),
		.din (slat_s12),
		.dout(slat_d)
	);

	always_ff @(posedge clk) begin
		ps_s22 <= q30_mul(ser_t[SER_N], slat_d);
	end

	// radicand in square metres q32
	logic [84:0]      prod_d;
	logic             psneg_d;
	logic [87:0]      base;
	logic [87:0]      term;
	logic [87:0]      rad;
	logic             neg_rad;
	logic [RAD_W-1:0] rad_s25;
	logic             flag_s25;

	afp_mul #(.AW(Q30_W), .BW(51)) u_mul_term (
		.clk (clk),
		.a   (ps_s22[Q30_W-1] ? Q30_W'(-ps_s22) : Q30_W'(ps_s22)),
		.b   (radius_term_q),
		.prod(prod_d)
	);

	afp_dly #(.W(1), .D(2)) u_psneg_dly (
		.clk (clk),
		.din (ps_s22[Q30_W-1]),
		.dout(psneg_d)
	);

	always_comb begin
		base    = 88'({rho_origin_sq_q, 32'd0});
		term    = 88'({prod_d, 2'b00});
		neg_rad = !psneg_d && (term > base);
		if (psneg_d) begin
			rad = base + term;
		end else if (neg_rad) begin
			rad = '0;
		end else begin
			rad = base - term;
		end
	end

	// radicands beyond the root range pin the root at all ones
	always_ff @(posedge clk) begin
		rad_s25  <= (rad[87:RAD_W] != '0) ? '1 : rad[RAD_W-1:0];
		flag_s25 <= neg_rad;
	end

	// square root chain
	logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
	logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];

	assign sq_rad[0]  = rad_s25;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		afp_sqrt_cell u_cell (
			.clk     (clk),
			.rad_in  (sq_rad[i]),
			.rem_in  (sq_rem[i]),
			.root_in (sq_root[i]),
			.rad_out (sq_rad[i+1]),
			.rem_out (sq_rem[i+1]),
			.root_out(sq_root[i+1])
		);
	end

	logic [RHO_W-1:0] rho_s69;

	always_ff @(posedge clk) begin
		if (RSH == 0) begin
			rho_s69 <= RHO_W'(sq_root[ROOT_W]);
		end else begin
			rho_s69 <= (RHO_W'(sq_root[ROOT_W]) + (RHO_W'(1) << RND)) >> RSH;
		end
	end

	// rho times sine and cosine of the cone angle
	logic [2*Q30_W-1:0] trig_d;
	q30_t               asin_d;
	q30_t               acos_d;
	logic [1:0]         sgn_d;
	logic               flag_d;
	logic [SC_W-1:0]    prod_e;
	logic [SC_W-1:0]    prod_f;

	afp_dly #(.W(2*Q30_W), .D(55)) u_trig_dly (
		.clk (clk),
		.din ({asin_s14, acos_s14}),
		.dout(trig_d)
	);

	assign asin_d = trig_d[2*Q30_W-1:Q30_W];
	assign acos_d = trig_d[Q30_W-1:0];

	afp_mul #(.AW(RHO_W), .BW(Q30_W)) u_mul_east (
		.clk (clk),
		.a   (rho_s69),
		.b   (asin_d[Q30_W-1] ? Q30_W'(-asin_d) : Q30_W'(asin_d)),
		.prod(prod_e)
	);

	afp_mul #(.AW(RHO_W), .BW(Q30_W)) u_mul_north (
		.clk (clk),
		.a   (rho_s69),
		.b   (acos_d[Q30_W-1] ? Q30_W'(-acos_d) : Q30_W'(acos_d)),
		.prod(prod_f)
	);

	afp_dly #(.W(2), .D(2)) u_sgn_dly (
		.clk (clk),
		.din ({asin_d[Q30_W-1], acos_d[Q30_W-1]}),
		.dout(sgn_d)
	);

	afp_dly #(.W(1), .D(46)) u_flag_dly (
		.clk (clk),
		.din (flag_s25),
		.dout(flag_d)
	);

	logic [SC_W:0]           re;
	logic [SC_W:0]           rn;
	logic signed [SV_W-1:0]  me;
	logic signed [SV_W-1:0]  mn;
	logic signed [SV_W-1:0]  ve_s72;
	logic signed [SV_W-1:0]  vn_s72;
	logic                    flag_s72;

	always_comb begin
		re = (SC_W+1)'(prod_e) + (SC_W+1)'(536870912);
		rn = (SC_W+1)'(prod_f) + (SC_W+1)'(536870912);
		me = $signed({1'b0, re[SC_W:30]});
		mn = $signed({1'b0, rn[SC_W:30]});
	end

	always_ff @(posedge clk) begin
		ve_s72   <= sgn_d[1] ? -me : me;
		vn_s72   <= sgn_d[0] ? -mn : mn;
		flag_s72 <= flag_d;
	end

	// offsets and clamp
	logic signed [SUM_W-1:0] east_sum;
	logic signed [SUM_W-1:0] north_sum;
	logic signed [SUM_W-1:0] east_cl;
	logic signed [SUM_W-1:0] north_cl;
	logic                    sat;

	always_comb begin
		east_sum  = SUM_W'(ve_s72) + SUM_W'(false_easting_q);
		north_sum = $signed(SUM_W'(rho_base_q)) - SUM_W'(vn_s72);
		sat       = 1'b0;
		east_cl   = east_sum;
		north_cl  = north_sum;
		if (east_sum > OUT_LIM) begin
			east_cl = OUT_LIM;
			sat     = 1'b1;
		end else if (east_sum < -OUT_LIM) begin
			east_cl = -OUT_LIM;
			sat     = 1'b1;
		end
		if (north_sum > OUT_LIM) begin
			north_cl = OUT_LIM;
			sat      = 1'b1;
		end else if (north_sum < -OUT_LIM) begin
			north_cl = -OUT_LIM;
			sat      = 1'b1;
		end
	end

	logic signed [34:0] northing_q;
	logic signed [34:0] easting_q;
	logic               oor_q;

	always_ff @(posedge clk) begin
		northing_q <= 35'(north_cl);
		easting_q  <= 35'(east_cl);
		oor_q      <= flag_s72 || sat;
	end

	assign done         = vld_q[PIPE_LAT-1];
	assign northing     = northing_q;
	assign easting      = easting_q;
	assign out_of_range = oor_q;

endmodule

// File: hdl/afp_checker.sv
// ----------------------------------------------------------------------------
// afp_checker
// port-level checks on busy, request and result timing and output range of the projection core
// ----------------------------------------------------------------------------
`include "albers_forward_projection_core_defines.svh"

module afp_checker import afp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [34:0] northing,
	input logic signed [34:0] easting
);

	// both coordinates within the clamp limits
	logic in_range;

	assign in_range = (northing <= 35'sd8589934592) && (northing >= -35'sd8589934592)
		&& (easting <= 35'sd8589934592) && (easting >= -35'sd8589934592);

	`AFP_ASSERT_NOW(a_never_busy, !busy, "busy raised on a streaming core")
	`AFP_ASSERT_IMP(a_request_done, start && !busy, ##PIPE_LAT done, "result strobe missing")
	`AFP_ASSERT_IMP(a_done_source, done, $past(start && !busy, PIPE_LAT), "result with no request")
	`AFP_ASSERT_IMP(a_clamped, done, in_range, "result beyond clamp")

endmodule

bind albers_forward_projection_core afp_checker u_afp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.northing(northing),
	.easting (easting)
);

// File: tb/albers_forward_projection_checker.sv
// ----------------------------------------------------------------------------
// albers forward projection checker
// tracks the register writes, predicts northing, easting and the range flag
// for every accepted request and compares them with each done strobe in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module albers_forward_projection_checker import afp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [50:0]        wr_data,
	input  logic signed [31:0] latitude,
	input  logic signed [32:0] longitude,
	input  logic               done,
	input  logic signed [34:0] northing,
	input  logic signed [34:0] easting,
	input  logic               out_of_range,
	output int                 pending,
	output int                 mismatches
);

	typedef struct packed {
		logic [34:0] north;
		logic [34:0] east;
		logic        flag;
	} grid_point_t;

	localparam longint LIMIT_33 = 64'sd1 << 33;
	localparam longint HALF_PI_K = 64'sd1686629713;
	localparam longint ECC_K = 64'sd88338731;
	localparam longint UNIT_Q30 = 64'sd1 << 30;
	localparam longint SERIES_K [7] = '{715827883, 644245094, 613566757, 596523236,
		585677359, 578168674, 572662306};

	logic signed [32:0] cen_lon;
	logic [40:0] cone_k;
	logic [50:0] rho0_sq;
	logic [50:0] rad_term;
	logic [33:0] rho_at_base;
	logic signed [34:0] east_offset;

	grid_point_t projected_q[$];

	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// signed product scaled down by n, magnitude rounded half up
	function automatic longint qmul(input longint a, input longint b, input int n);
		longint unsigned p;
		p = (abs64(a) * abs64(b) + (64'd1 << (n - 1))) >> n;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic void quarter_sincos(input logic [63:0] quarter, input bit neg,
			output longint sn, output longint cs);
		logic [63:0] k;
		longint fr, r, s2, ts, tc, sv, cv;
		k = quarter >> 32;
		fr = longint'(quarter[31:0]);
		if (fr >= (64'sd1 << 31)) begin
			k++;
			fr -= 64'sd1 << 32;
		end
		r = qmul(fr, HALF_PI_K, 32);
		s2 = qmul(r, r, 30);
		ts = 213044 - qmul(s2, 2959, 30);
		ts = 8947849 - qmul(s2, ts, 30);
		ts = 178956971 - qmul(s2, ts, 30);
		ts = UNIT_Q30 - qmul(s2, ts, 30);
		sv = qmul(r, ts, 30);
		tc = 26631 - qmul(s2, 296, 30);
		tc = 1491308 - qmul(s2, tc, 30);
		tc = 44739243 - qmul(s2, tc, 30);
		tc = 536870912 - qmul(s2, tc, 30);
		cv = UNIT_Q30 - qmul(s2, tc, 30);
		case (quad_t'(k[1:0]))
			QUAD_0: begin sn = sv; cs = cv; end
			QUAD_1: begin sn = cv; cs = -sv; end
			QUAD_2: begin sn = -sv; cs = -cv; end
			default: begin sn = -cv; cs = sv; end
		endcase
		if (neg)
			sn = -sn;
	endfunction

	function automatic longint rho_scaled(input longint unsigned rho, input longint f);
		logic [127:0] p;
		longint v;
		p = (128'(rho) * 128'(abs64(f)) + (128'd1 << 29)) >> 30;
		v = longint'(p[63:0]);
		return f < 0 ? -v : v;
	endfunction

	function automatic longint clamp33(input longint v, inout bit flag);
		if (v > LIMIT_33) begin
			flag = 1'b1;
			return LIMIT_33;
		end
		if (v < -LIMIT_33) begin
			flag = 1'b1;
			return -LIMIT_33;
		end
		return v;
	endfunction

	function automatic grid_point_t project_point(input logic signed [31:0] lat_in,
			input logic signed [32:0] lon_in);
		longint lat, diff, asn, acs, slat, clat, x, xx, t, ps, east, north;
		logic [127:0] prod, term, base, rad;
		logic [63:0] radq, quarter, lq, root, c, rho;
		bit flag;
		grid_point_t res;
		flag = 1'b0;
		lat = lat_in;
		diff = longint'(cen_lon) - longint'(lon_in);
		prod = 128'(abs64(diff)) * 128'(cone_k) + (128'd1 << 31);
		radq = prod[95:32];
		prod = 128'(radq) * 128'(TWO_OVER_PI_Q64);
		quarter = prod[127:64];
		quarter_sincos(quarter, diff < 0, asn, acs);
		lq = ((abs64(lat) << (32 - ANGLE_FRAC_BITS_DEF)) + 64'd45) / 64'd90;
		quarter_sincos(lq, lat < 0, slat, clat);
		x = qmul(slat, ECC_K, 30);
		xx = qmul(x, x, 30);
		t = SERIES_K[6];
		for (int b = 5; b >= 0; b--)
			t = SERIES_K[b] + qmul(t, xx, 30);
		t = UNIT_Q30 + qmul(t, xx, 30);
		ps = qmul(t, slat, 30);
		term = (128'(abs64(ps)) * 128'(rad_term)) << 2;
		base = 128'(rho0_sq) << 32;
		if (ps >= 0) begin
			if (term > base) begin
				flag = 1'b1;
				rad = '0;
			end else begin
				rad = base - term;
			end
		end else begin
			rad = base + term;
		end
		root = '0;
		for (int b = 42; b >= 0; b--) begin
			c = root | (64'd1 << b);
			if (128'(c) * 128'(c) <= rad)
				root = c;
		end
		rho = (root + (64'd1 << (15 - DIST_FRAC_BITS_DEF))) >> (16 - DIST_FRAC_BITS_DEF);
		east = clamp33(rho_scaled(rho, asn) + longint'(east_offset), flag);
		north = clamp33(longint'(rho_at_base) - rho_scaled(rho, acs), flag);
		res.north = north[34:0];
		res.east = east[34:0];
		res.flag = flag;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_lon     <= CENTRAL_LON_RST;
			cone_k      <= CONE_CONST_RST;
			rho0_sq     <= RHO_ORIGIN_SQ_RST;
			rad_term    <= RADIUS_TERM_RST;
			rho_at_base <= RHO_BASE_RST;
			east_offset <= FALSE_EASTING_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTRAL_LON:   cen_lon     <= wr_data[32:0];
				REG_CONE_CONST:    cone_k      <= wr_data[40:0];
				REG_RHO_ORIGIN_SQ: rho0_sq     <= wr_data[50:0];
				REG_RADIUS_TERM:   rad_term    <= wr_data[50:0];
				REG_RHO_BASE:      rho_at_base <= wr_data[33:0];
				REG_FALSE_EASTING: east_offset <= wr_data[34:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		grid_point_t want;
		if (arst_n) begin
			if (done) begin
				if (projected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result n=%0d e=%0d f=%0d", northing, easting,
							out_of_range);
				end else begin
					want = projected_q.pop_front();
					if (want.north !== northing || want.east !== easting
							|| want.flag !== out_of_range) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp n=%0d e=%0d f=%0d got n=%0d e=%0d f=%0d",
								$signed(want.north), $signed(want.east), want.flag,
								northing, easting, out_of_range);
					end
				end
			end
			if (start && !busy)
				projected_q.push_back(project_point(latitude, longitude));
		end else begin
			mismatches = 0;
		end
	end

	assign pending = projected_q.size();

endmodule

// File: tb/albers_forward_projection_core_tb.sv
// ----------------------------------------------------------------------------
// albers forward projection core testbench
// streams directed and random coordinate requests through several register
// settings with random gaps; the checker predicts and compares each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module albers_forward_projection_core_tb import afp_pkg::*; ();

	localparam longint DEG = 64'sd1 << 24;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               wr_en;
	logic [2:0]         wr_index;
	logic [50:0]        wr_data;
	logic signed [31:0] latitude;
	logic signed [32:0] longitude;
	logic               done;
	logic signed [34:0] northing;
	logic signed [34:0] easting;
	logic               out_of_range;
	int                 pending;
	int                 mismatches;
	int                 calm;

	albers_forward_projection_core u_dut (.*);

	albers_forward_projection_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [50:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
	endtask

	task automatic send_point(input logic signed [31:0] lat, input logic signed [32:0] lon);
		if (!calm && $urandom_range(99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start     <= 1'b1;
		latitude  <= lat;
		longitude <= lon;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		wr_en <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic random_points(input int count);
		longint lon;
		longint lat;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 2 && i < count / 2 + 60);
			if ($urandom_range(9) < 8) begin
				lat = longint'($urandom_range(0, 3019898880)) - 1509949440;
				lon = longint'({$urandom, $urandom} % 64'd6039797761) - 3019898880;
			end else begin
				lat = longint'($signed($urandom));
				lon = longint'({$urandom, $urandom});
			end
			send_point(lat[31:0], lon[32:0]);
		end
		calm = 0;
	endtask

	initial begin
		calm      = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		wr_en     = 1'b0;
		wr_index  = REG_CENTRAL_LON;
		wr_data   = '0;
		latitude  = '0;
		longitude = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: poles, equator, field extremes, on and around the central meridian
		send_point(0, 96 * DEG);
		send_point(90 * DEG, 96 * DEG);
		send_point(-90 * DEG, 96 * DEG);
		send_point(32'sh7fffffff, 33'sh0ffffffff);
		send_point(32'sh80000000, 33'sh100000000);
		send_point(45 * DEG, 180 * DEG);
		send_point(45 * DEG, -180 * DEG);
		send_point(-45 * DEG, 0);
		send_point(29 * DEG + 1, 96 * DEG - 1);
		send_point(-1, 96 * DEG + 1);
		send_point(60 * DEG, 96 * DEG + 90 * DEG);
		send_point(60 * DEG, 96 * DEG - 90 * DEG);
		send_point(89 * DEG, -3019898880);
		send_point(-89 * DEG, 3019898880);
		random_points(200);
		drain();

		// upper extremes
		write_reg(REG_CENTRAL_LON, 51'(3019898880));
		write_reg(REG_CONE_CONST, 51'd1 << 40);
		write_reg(REG_RHO_ORIGIN_SQ, 51'd1 << 50);
		write_reg(REG_RADIUS_TERM, 51'd1 << 50);
		write_reg(REG_RHO_BASE, 51'd1 << 33);
		write_reg(REG_FALSE_EASTING, 51'(-(64'sd1 << 33)));
		drain();
		send_point(90 * DEG, -3019898880);
		send_point(-90 * DEG, 3019898880);
		random_points(180);
		drain();

		// lower extremes: zero origin radius forces a negative radicand north of the equator
		write_reg(REG_CENTRAL_LON, 51'(-64'sd3019898880));
		write_reg(REG_CONE_CONST, '0);
		write_reg(REG_RHO_ORIGIN_SQ, '0);
		write_reg(REG_RADIUS_TERM, 51'd1 << 50);
		write_reg(REG_RHO_BASE, '0);
		write_reg(REG_FALSE_EASTING, 51'd1 << 33);
		drain();
		send_point(45 * DEG, 0);
		send_point(-45 * DEG, 0);
		random_points(180);
		drain();

		// all ones, including the unused indexes
		for (int i = 0; i < 8; i++)
			write_reg(i[2:0], '1);
		drain();
		random_points(180);
		drain();

		// random mid-range settings
		write_reg(REG_CENTRAL_LON, 51'(longint'($urandom_range(0, 200)) * DEG - 100 * DEG));
		write_reg(REG_CONE_CONST, 51'({$urandom, $urandom} % (64'd1 << 40)));
		write_reg(REG_RHO_ORIGIN_SQ, 51'({$urandom, $urandom} % (64'd1 << 48)));
		write_reg(REG_RADIUS_TERM, 51'({$urandom, $urandom} % (64'd1 << 48)));
		write_reg(REG_RHO_BASE, 51'($urandom));
		write_reg(REG_FALSE_EASTING, 51'(longint'($signed($urandom))));
		drain();
		random_points(180);
		drain();

		// back to the standard constants
		write_reg(REG_CENTRAL_LON, 51'(CENTRAL_LON_RST));
		write_reg(REG_CONE_CONST, 51'(CONE_CONST_RST));
		write_reg(REG_RHO_ORIGIN_SQ, RHO_ORIGIN_SQ_RST);
		write_reg(REG_RADIUS_TERM, RADIUS_TERM_RST);
		write_reg(REG_RHO_BASE, 51'(RHO_BASE_RST));
		write_reg(REG_FALSE_EASTING, 51'(longint'(FALSE_EASTING_RST)));
		drain();
		random_points(180);
		drain();

		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: albers_forward_projection_core.f
+incdir+hdl
hdl/afp_pkg.sv
hdl/afp_dly.sv
hdl/afp_mul.sv
hdl/afp_horner_cell.sv
hdl/afp_sqrt_cell.sv
hdl/afp_sincos.sv
hdl/albers_forward_projection_core.sv
hdl/afp_checker.sv
tb/albers_forward_projection_checker.sv
tb/albers_forward_projection_core_tb.sv
